// ===== rtl/ricache_pkg.sv =====
// Shared constants, codes and record types of the reference-counted inode cache table.
`default_nettype none

package ricache_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = IDX_W + 1;

    localparam int MODE_W  = 2;
    localparam int DEV_W   = 8;
    localparam int NUM_W   = 16;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 2;
    localparam int REF_W   = 16;
    localparam int ENTRY_W = REF_W + DEV_W + NUM_W;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = MODE_W;
    localparam int OUT_DATA_W = 24;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET  = 2'd0,
        MODE_DUP  = 2'd1,
        MODE_PUT  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_NEW  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_SLOT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [REF_W-1:0] refs;
        logic [DEV_W-1:0] dev;
        logic [NUM_W-1:0] num;
    } entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
        logic [REF_W-1:0]  refs;
        logic              dropped;
    } result_t;

    function automatic logic [REF_W-1:0] bump(input logic [REF_W-1:0] r);
        logic [REF_W-1:0] v;
        v = (r == REF_MAX) ? r : r + REF_W'(1);
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ricache_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module ricache_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/refcounted_inode_cache_table_top.sv =====
// Top level of the reference-counted inode cache table.
//
// One request item enters on the s_axis channel; the request mode travels in tuser and the
// device number, inode number and slot travel in tdata. Every get, dup or put gives exactly
// one result item on the m_axis channel; a request with the unused mode is taken and dropped.
// The table lives in one RAM of ENTRIES words with a registered read port, and a get walks it
// one slot per cycle in ascending order until it hits or checks the last slot, and the block
// is ready again in the cycle the result is placed in the output register. Dup and put read
// and write back the addressed slot before their result goes to the output register.
// One request is in work at a time; s_axis_tready is high only while the block waits for one.
// The result sits in an output register, so the block takes the next request while an earlier
// result still waits; if the receiver stalls and a newer result is finished, that result is
// held until the output register frees. Reset clears all reference counts at once through
// a valid bit per entry and empties the output register; no clearing pass is needed.
`default_nettype none

module refcounted_inode_cache_table_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0: device_id[7:0], inode_number[15:0], slot_index[4:0], zero fill.
    input  wire logic [ricache_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: mode[1:0].
    input  wire logic [ricache_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // Fields from bit 0: result_slot[4:0], status[1:0], ref_after[15:0], last_dropped.
    output logic      [ricache_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int IDX_W   = ricache_pkg::IDX_W;
    localparam int CNT_W   = ricache_pkg::CNT_W;
    localparam int DEV_W   = ricache_pkg::DEV_W;
    localparam int NUM_W   = ricache_pkg::NUM_W;
    localparam int SLOT_W  = ricache_pkg::SLOT_W;
    localparam int REF_W   = ricache_pkg::REF_W;
    localparam int ENTRY_W = ricache_pkg::ENTRY_W;
    localparam int ENTRIES = ricache_pkg::ENTRIES;

    ricache_pkg::state_t  state_reg, state_next;
    ricache_pkg::mode_t   mode_reg, mode_next;
    logic [DEV_W-1:0]     dev_reg, dev_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 have_free_reg, have_free_next;
    logic [IDX_W-1:0]     free_slot_reg, free_slot_next;
    ricache_pkg::result_t res_reg, res_next;
    ricache_pkg::result_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    ricache_pkg::entry_t  ram_wentry;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    ricache_pkg::entry_t  rd_entry;
    logic [REF_W-1:0]     rd_refs;
    logic [REF_W-1:0]     new_refs;
    logic                 live;
    logic                 match;
    logic                 last_chk;
    logic                 free_any;
    logic [IDX_W-1:0]     free_pick;
    logic                 scan_done;
    logic                 slot_ok;
    logic [IDX_W-1:0]     slot_addr;
    logic                 in_accept;
    logic                 out_free;

    ricache_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // An entry that was never written reads as free.
    always_comb
    begin
        rd_entry  = ricache_pkg::entry_t'(ram_rdata);
        rd_refs   = valid_reg[chk_idx_reg] ? rd_entry.refs : '0;
        live      = (rd_refs != '0);
        match     = live && (rd_entry.dev == dev_reg) && (rd_entry.num == num_reg);
        last_chk  = (chk_idx_reg == IDX_W'(ENTRIES - 1));
        free_any  = have_free_reg || !live;
        free_pick = have_free_reg ? free_slot_reg : chk_idx_reg;
        scan_done = chk_valid_reg && (match || last_chk);
        slot_ok   = (int'(slot_reg) < ENTRIES);
        slot_addr = IDX_W'(slot_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ricache_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    case (ricache_pkg::mode_t'(s_axis_tuser))
                        ricache_pkg::MODE_GET:  state_next = ricache_pkg::S_SCAN;
                        ricache_pkg::MODE_DUP:  state_next = ricache_pkg::S_READ;
                        ricache_pkg::MODE_PUT:  state_next = ricache_pkg::S_READ;
                        default:                state_next = ricache_pkg::S_IDLE;
                    endcase
                end
            end
            ricache_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ricache_pkg::S_EMIT;
                end
            end
            ricache_pkg::S_READ:
            begin
                state_next = slot_ok ? ricache_pkg::S_SLOT : ricache_pkg::S_EMIT;
            end
            ricache_pkg::S_SLOT:
            begin
                state_next = ricache_pkg::S_EMIT;
            end
            ricache_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ricache_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ricache_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        dev_next       = dev_reg;
        num_next       = num_reg;
        slot_next      = slot_reg;
        scan_addr_next = scan_addr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        have_free_next = have_free_reg;
        free_slot_next = free_slot_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        valid_next     = valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx_reg;
        ram_wentry     = '{refs: rd_refs, dev: dev_reg, num: num_reg};
        ram_re         = 1'b0;
        ram_raddr      = scan_addr_reg[IDX_W-1:0];
        new_refs       = rd_refs;
        s_axis_tready  = (state_reg == ricache_pkg::S_IDLE);

        case (state_reg)
            ricache_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next      = ricache_pkg::mode_t'(s_axis_tuser);
                    dev_next       = s_axis_tdata[DEV_W-1:0];
                    num_next       = s_axis_tdata[DEV_W +: NUM_W];
                    slot_next      = s_axis_tdata[DEV_W + NUM_W +: SLOT_W];
                    scan_addr_next = '0;
                    have_free_next = 1'b0;
                end
            end
            ricache_pkg::S_SCAN:
            begin
                if (scan_addr_reg != CNT_W'(ENTRIES))
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_addr_reg[IDX_W-1:0];
                end
                if (chk_valid_reg)
                begin
                    if (match)
                    begin
                        new_refs   = ricache_pkg::bump(rd_refs);
                        ram_we     = 1'b1;
                        ram_waddr  = chk_idx_reg;
                        ram_wentry = '{refs: new_refs, dev: dev_reg, num: num_reg};
                        res_next   = '{slot: SLOT_W'(chk_idx_reg), status: ricache_pkg::STAT_OK,
                                       refs: new_refs, dropped: 1'b0};
                    end
                    else if (last_chk)
                    begin
                        if (free_any)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = free_pick;
                            ram_wentry = '{refs: REF_W'(1), dev: dev_reg, num: num_reg};
                            res_next   = '{slot: SLOT_W'(free_pick),
                                           status: ricache_pkg::STAT_NEW,
                                           refs: REF_W'(1), dropped: 1'b0};
                        end
                        else
                        begin
                            res_next = '{slot: '0, status: ricache_pkg::STAT_FULL,
                                         refs: '0, dropped: 1'b0};
                        end
                    end
                    else if (!live && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_slot_next = chk_idx_reg;
                    end
                end
            end
            ricache_pkg::S_READ:
            begin
                if (slot_ok)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = slot_addr;
                    chk_idx_next = slot_addr;
                end
                else
                begin
                    res_next = '{slot: slot_reg, status: ricache_pkg::STAT_FREE,
                                 refs: '0, dropped: 1'b0};
                end
            end
            ricache_pkg::S_SLOT:
            begin
                if (!live)
                begin
                    res_next = '{slot: slot_reg, status: ricache_pkg::STAT_FREE,
                                 refs: '0, dropped: 1'b0};
                end
                else
                begin
                    if (mode_reg == ricache_pkg::MODE_DUP)
                    begin
                        new_refs = ricache_pkg::bump(rd_refs);
                    end
                    else
                    begin
                        new_refs = rd_refs - REF_W'(1);
                    end
                    ram_we     = 1'b1;
                    ram_waddr  = chk_idx_reg;
                    ram_wentry = '{refs: new_refs, dev: rd_entry.dev, num: rd_entry.num};
                    res_next   = '{slot: slot_reg, status: ricache_pkg::STAT_OK,
                                   refs: new_refs,
                                   dropped: (mode_reg == ricache_pkg::MODE_PUT) &&
                                            (new_refs == '0)};
                end
            end
            ricache_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ricache_pkg::S_IDLE;
            chk_valid_reg <= 1'b0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            have_free_reg <= have_free_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        dev_reg       <= dev_next;
        num_reg       <= num_next;
        slot_reg      <= slot_next;
        scan_addr_reg <= scan_addr_next;
        chk_idx_reg   <= chk_idx_next;
        free_slot_reg <= free_slot_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.dropped, out_reg.refs, out_reg.status, out_reg.slot};

endmodule

`default_nettype wire

// ===== rtl/ricache_checker.sv =====
// Port-level checker for the inode cache table top level and its bind statement.
`default_nettype none

module ricache_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic [ricache_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input wire logic [ricache_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [ricache_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic                           in_acc;
    logic [ricache_pkg::STAT_W-1:0] st;
    logic [ricache_pkg::REF_W-1:0]  refs;
    logic [ricache_pkg::SLOT_W-1:0] slot;
    logic                           dropped;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign slot    = m_axis_tdata[4:0];
    assign st      = m_axis_tdata[6:5];
    assign refs    = m_axis_tdata[22:7];
    assign dropped = m_axis_tdata[23];

    // A stalled result stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");

    // No result can appear in the cycle right after a request is taken.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(m_axis_tvalid))
        else $error("Result appeared too early after a request.");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == ricache_pkg::STAT_FULL) |->
            (refs == '0) && (slot == '0) && !dropped)
        else $error("Full result carries nonzero fields.");

    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == ricache_pkg::STAT_NEW) |-> (refs == 16'd1) && !dropped)
        else $error("Newly claimed slot does not hold one reference.");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dropped |-> (refs == '0) && (st == ricache_pkg::STAT_OK))
        else $error("Last reference flag with a live count.");

endmodule

bind refcounted_inode_cache_table_top ricache_checker u_ricache_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/refcounted_inode_cache_table_checker.sv =====
// Checker that predicts and compares the result items of the inode cache table.
module refcounted_inode_cache_table_checker
    import ricache_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // Fields from bit 0: device_id[7:0], inode_number[15:0], slot_index[4:0], zero fill.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: result_slot[4:0], status[1:0], ref_after[15:0], last_dropped.
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DEV_W-1:0] slot_dev  [ENTRIES];
    logic [NUM_W-1:0] slot_num  [ENTRIES];
    logic [REF_W-1:0] slot_refs [ENTRIES];
    result_t          pending_results [$];

    function automatic logic [REF_W-1:0] inc_sat(input logic [REF_W-1:0] c);
        return (c == REF_MAX) ? c : c + 1'b1;
    endfunction

    task automatic apply_request(input mode_t m, input logic [DEV_W-1:0] dev,
                                 input logic [NUM_W-1:0] num, input logic [SLOT_W-1:0] idx);
        result_t r;
        int      free_idx;
        bit      hit;
        r = '0;
        free_idx = -1;
        hit = 1'b0;
        if (m == MODE_NONE)
            return;
        if (m == MODE_GET)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!hit && slot_refs[i] != '0 && slot_dev[i] == dev && slot_num[i] == num)
                begin
                    hit = 1'b1;
                    slot_refs[i] = inc_sat(slot_refs[i]);
                    r.slot = SLOT_W'(i);
                    r.status = STAT_OK;
                    r.refs = slot_refs[i];
                end
                if (free_idx < 0 && slot_refs[i] == '0)
                    free_idx = i;
            end
            if (!hit && free_idx < 0)
                r.status = STAT_FULL;
            else if (!hit)
            begin
                slot_dev[free_idx] = dev;
                slot_num[free_idx] = num;
                slot_refs[free_idx] = REF_W'(1);
                r.slot = SLOT_W'(free_idx);
                r.status = STAT_NEW;
                r.refs = REF_W'(1);
            end
        end
        else if (int'(idx) >= ENTRIES || slot_refs[idx] == '0)
        begin
            r.slot = idx;
            r.status = STAT_FREE;
        end
        else if (m == MODE_DUP)
        begin
            slot_refs[idx] = inc_sat(slot_refs[idx]);
            r.slot = idx;
            r.status = STAT_OK;
            r.refs = slot_refs[idx];
        end
        else
        begin
            slot_refs[idx] = slot_refs[idx] - 1'b1;
            r.slot = idx;
            r.status = STAT_OK;
            r.refs = slot_refs[idx];
            r.dropped = (slot_refs[idx] == '0);
        end
        pending_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_refs[i] = '0;
            pending_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result item with no request waiting: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    got.slot = m_axis_tdata[0 +: SLOT_W];
                    got.status = status_t'(m_axis_tdata[SLOT_W +: STAT_W]);
                    got.refs = m_axis_tdata[SLOT_W+STAT_W +: REF_W];
                    got.dropped = m_axis_tdata[SLOT_W+STAT_W+REF_W];
                    if (got.slot !== want.slot)
                    begin
                        $error("result_slot: expected %0d, got %0d", want.slot, got.slot);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.refs !== want.refs)
                    begin
                        $error("ref_after: expected %0d, got %0d", want.refs, got.refs);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        $error("last_dropped: expected %0d, got %0d", want.dropped,
                               got.dropped);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_request(mode_t'(s_axis_tuser), s_axis_tdata[0 +: DEV_W],
                              s_axis_tdata[DEV_W +: NUM_W],
                              s_axis_tdata[DEV_W+NUM_W +: SLOT_W]);
        end
        pending = pending_results.size();
    end

endmodule

// ===== verif/refcounted_inode_cache_table_top_test.sv =====
// Testbench top that drives request items into the inode cache table and gives the verdict.
module refcounted_inode_cache_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ricache_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1580;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent;
    int stall_left;
    int quiet_cycles;
    bit sender_idle = 1'b1;
    bit steady = 1'b0;

    always #10 clk = ~clk;

    refcounted_inode_cache_table_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    refcounted_inode_cache_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    task automatic send_item(input mode_t m, input logic [DEV_W-1:0] dev,
                             input logic [NUM_W-1:0] num, input logic [SLOT_W-1:0] idx);
        int gap;
        gap = (sender_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W-DEV_W-NUM_W-SLOT_W){1'b0}}, idx, num, dev};
        s_axis_tuser <= m;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            stall_left <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [DEV_W-1:0]  dev;
        logic [NUM_W-1:0]  num;
        logic [SLOT_W-1:0] idx;
        int                get_pct;
        int                epoch_left;
        int                rand_count;
        int                r;
        rand_count = 0;
        epoch_left = 0;
        get_pct = 50;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(MODE_GET, 8'h00, 16'h0000, 5'd31);
        send_item(MODE_GET, 8'hFF, 16'hFFFF, 5'd0);
        send_item(MODE_GET, 8'h00, 16'h0000, 5'd0);
        send_item(MODE_GET, 8'h00, 16'hFFFF, 5'd0);
        send_item(MODE_GET, 8'hFF, 16'h0000, 5'd0);
        send_item(MODE_DUP, 8'hFF, 16'hFFFF, 5'd1);
        send_item(MODE_PUT, 8'h00, 16'h0000, 5'd0);
        send_item(MODE_PUT, 8'h00, 16'h0000, 5'd0);
        send_item(MODE_PUT, 8'h00, 16'h0000, 5'd0);
        send_item(MODE_DUP, 8'h00, 16'h0000, 5'd0);
        send_item(MODE_DUP, 8'h00, 16'h0000, 5'd31);
        send_item(MODE_PUT, 8'hFF, 16'hFFFF, 5'd31);
        send_item(MODE_NONE, 8'hFF, 16'hFFFF, 5'd31);
        send_item(MODE_GET, 8'h01, 16'h0001, 5'd0);
        send_item(MODE_PUT, 8'h00, 16'h0000, 5'd2);
        send_item(MODE_GET, 8'h00, 16'hFFFF, 5'd31);
        send_item(MODE_DUP, 8'hFF, 16'hFFFF, 5'd16);
        drain_results();

        while (rand_count < RANDOM_ITEMS)
        begin
            if (epoch_left == 0)
            begin
                epoch_left = 100;
                get_pct = $urandom_range(15, 85);
                sender_idle = ($urandom_range(0, 3) != 0);
                steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
            epoch_left--;
            dev = DEV_W'($urandom);
            num = NUM_W'($urandom);
            idx = SLOT_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(MODE_NONE, dev, num, idx);
            else if (r < 3 + get_pct * 97 / 100)
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    dev = 8'h55 * DEV_W'($urandom_range(0, 3));
                    num = {2'($urandom_range(0, 3)), 12'h000, 2'($urandom_range(0, 3))};
                end
                send_item(MODE_GET, dev, num, idx);
                rand_count++;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    idx = SLOT_W'($urandom_range(0, 11));
                send_item(($urandom_range(0, 2) == 0) ? MODE_DUP : MODE_PUT, dev, num, idx);
                rand_count++;
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (40) @(negedge clk);
        $display("Sent %0d request items (directed corner cases, then %0d random requests).",
                 items_sent, rand_count);
        $display("Compared %0d result items against the predicted table.", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
